// ----- src/crg_pkg.sv -----
// Shared types and constants for the camera ray generator.
package crg_pkg;

    localparam int FRAME_WIDTH  = 1024;
    localparam int FRAME_HEIGHT = 768;
    localparam int SQRT_STEPS   = 32;
    localparam int DIV_STEPS    = 15;

    localparam logic [2:0] REG_POS_X = 3'd0;
    localparam logic [2:0] REG_POS_Y = 3'd1;
    localparam logic [2:0] REG_POS_Z = 3'd2;
    localparam logic [2:0] REG_DIR_X = 3'd3;
    localparam logic [2:0] REG_DIR_Y = 3'd4;
    localparam logic [2:0] REG_DIR_Z = 3'd5;
    localparam logic [2:0] REG_SCALE = 3'd6;

    localparam logic signed [15:0] DIR_Z_RESET = 16'sd16384;
    localparam logic [31:0]        SCALE_RESET = 32'd29360;

    typedef logic signed [15:0] crg_q14_t;
    typedef logic signed [63:0] crg_wide_t;

    typedef enum logic [1:0] {
        KIND_PIXEL,
        KIND_FWD,
        KIND_RIGHT
    } crg_kind_t;

    typedef struct packed {
        crg_kind_t kind;
        logic      pre_bad;
    } crg_meta_t;

endpackage

// ----- src/crg_cfg_if.sv -----
// Configuration write channel.
interface crg_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- src/crg_pix_if.sv -----
// Pixel coordinate channel.
interface crg_pix_if;
    logic        valid;
    logic        ready;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;

    modport source (output valid, pixel_x, pixel_y, input ready);
    modport sink (input valid, pixel_x, pixel_y, output ready);
endinterface

// ----- src/crg_ray_if.sv -----
// Ray result channel.
interface crg_ray_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [15:0] ray_dir_x;
    logic signed [15:0] ray_dir_y;
    logic signed [15:0] ray_dir_z;
    logic               degenerate;

    modport source (output valid, origin_x, origin_y, origin_z, ray_dir_x, ray_dir_y,
                    ray_dir_z, degenerate, input ready);
    modport sink (input valid, origin_x, origin_y, origin_z, ray_dir_x, ray_dir_y,
                  ray_dir_z, degenerate, output ready);
endinterface

// ----- src/crg_norm3.sv -----
// Pipelined three-component normalizer to Q2.14 (range shift, square root, divide).
module crg_norm3 (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  crg_pkg::crg_wide_t [2:0]    in_v,
    input  crg_pkg::crg_meta_t          in_meta,
    output logic                        out_valid,
    output crg_pkg::crg_q14_t [2:0]     out_q,
    output logic                        out_zero,
    output crg_pkg::crg_meta_t          out_meta
);
    import crg_pkg::*;

    // stage 1: magnitudes
    logic              s1_valid_reg;
    logic [62:0]       s1_mag_reg [3];
    logic [2:0]        s1_neg_reg;
    crg_meta_t         s1_meta_reg;
    logic [62:0]       s1_mag_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s1_mag_next[i] = in_v[i][63] ? 63'(-in_v[i]) : in_v[i][62:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s1_mag_reg   <= s1_mag_next;
            s1_neg_reg   <= {in_v[2][63], in_v[1][63], in_v[0][63]};
            s1_meta_reg  <= in_meta;
        end
    end

    // stage 2: leading one of the largest magnitude
    logic              s2_valid_reg;
    logic [62:0]       s2_mag_reg [3];
    logic [2:0]        s2_neg_reg;
    crg_meta_t         s2_meta_reg;
    logic              s2_zero_reg;
    logic              s2_shr_reg;
    logic [5:0]        s2_amt_reg;
    logic [62:0]       mx;
    logic [5:0]        msb;
    logic              s2_shr_next;
    logic [5:0]        s2_amt_next;

    always_comb
    begin
        mx = s1_mag_reg[0];
        if (s1_mag_reg[1] > mx)
        begin
            mx = s1_mag_reg[1];
        end
        if (s1_mag_reg[2] > mx)
        begin
            mx = s1_mag_reg[2];
        end
        msb = '0;
        for (int i = 0; i < 63; i++)
        begin
            if (mx[i])
            begin
                msb = 6'(i);
            end
        end
        s2_shr_next = msb > 6'd30;
        s2_amt_next = s2_shr_next ? msb - 6'd30 : 6'd30 - msb;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg;
            s2_mag_reg   <= s1_mag_reg;
            s2_neg_reg   <= s1_neg_reg;
            s2_meta_reg  <= s1_meta_reg;
            s2_zero_reg  <= mx == '0;
            s2_shr_reg   <= s2_shr_next;
            s2_amt_reg   <= s2_amt_next;
        end
    end

    // stage 3: shift into range
    logic              s3_valid_reg;
    logic [30:0]       s3_m_reg [3];
    logic [2:0]        s3_neg_reg;
    crg_meta_t         s3_meta_reg;
    logic              s3_zero_reg;
    logic [30:0]       s3_m_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s3_m_next[i] = s2_shr_reg ? 31'(s2_mag_reg[i] >> s2_amt_reg)
                                      : 31'(s2_mag_reg[i] << s2_amt_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_valid_reg <= s2_valid_reg;
            s3_m_reg     <= s3_m_next;
            s3_neg_reg   <= s2_neg_reg;
            s3_meta_reg  <= s2_meta_reg;
            s3_zero_reg  <= s2_zero_reg;
        end
    end

    // stage 4: squares
    logic              s4_valid_reg;
    logic [30:0]       s4_m_reg [3];
    logic [61:0]       s4_sq_reg [3];
    logic [2:0]        s4_neg_reg;
    crg_meta_t         s4_meta_reg;
    logic              s4_zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s4_valid_reg <= s3_valid_reg;
            s4_m_reg     <= s3_m_reg;
            for (int i = 0; i < 3; i++)
            begin
                s4_sq_reg[i] <= 62'(s3_m_reg[i]) * 62'(s3_m_reg[i]);
            end
            s4_neg_reg   <= s3_neg_reg;
            s4_meta_reg  <= s3_meta_reg;
            s4_zero_reg  <= s3_zero_reg;
        end
    end

    // square root, one result bit per stage
    logic              sq_valid_reg [SQRT_STEPS+1];
    logic [33:0]       sq_rem_reg   [SQRT_STEPS+1];
    logic [31:0]       sq_root_reg  [SQRT_STEPS+1];
    logic [63:0]       sq_n_reg     [SQRT_STEPS+1];
    logic [30:0]       sq_m_reg     [SQRT_STEPS+1][3];
    logic [2:0]        sq_neg_reg   [SQRT_STEPS+1];
    logic              sq_zero_reg  [SQRT_STEPS+1];
    crg_meta_t         sq_meta_reg  [SQRT_STEPS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            sq_valid_reg[0] <= s4_valid_reg;
            sq_rem_reg[0]   <= '0;
            sq_root_reg[0]  <= '0;
            sq_n_reg[0]     <= 64'(s4_sq_reg[0]) + 64'(s4_sq_reg[1]) + 64'(s4_sq_reg[2]);
            sq_m_reg[0]     <= s4_m_reg;
            sq_neg_reg[0]   <= s4_neg_reg;
            sq_zero_reg[0]  <= s4_zero_reg;
            sq_meta_reg[0]  <= s4_meta_reg;
        end
    end

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        logic [35:0] rs;
        logic [35:0] trial;
        logic        ge;

        assign rs    = {sq_rem_reg[k], sq_n_reg[k][63:62]};
        assign trial = {2'b00, sq_root_reg[k], 2'b01};
        assign ge    = rs >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_valid_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                sq_valid_reg[k+1] <= sq_valid_reg[k];
                sq_rem_reg[k+1]   <= ge ? 34'(rs - trial) : rs[33:0];
                sq_root_reg[k+1]  <= {sq_root_reg[k][30:0], ge};
                sq_n_reg[k+1]     <= {sq_n_reg[k][61:0], 2'b00};
                sq_m_reg[k+1]     <= sq_m_reg[k];
                sq_neg_reg[k+1]   <= sq_neg_reg[k];
                sq_zero_reg[k+1]  <= sq_zero_reg[k];
                sq_meta_reg[k+1]  <= sq_meta_reg[k];
            end
        end
    end

    // rounded divide by the length, one quotient bit per stage
    logic              dv_valid_reg [DIV_STEPS+1];
    logic [31:0]       dv_len_reg   [DIV_STEPS+1];
    logic [31:0]       dv_rem_reg   [DIV_STEPS+1][3];
    logic [14:0]       dv_low_reg   [DIV_STEPS+1][3];
    logic [14:0]       dv_q_reg     [DIV_STEPS+1][3];
    logic [2:0]        dv_neg_reg   [DIV_STEPS+1];
    logic              dv_zero_reg  [DIV_STEPS+1];
    crg_meta_t         dv_meta_reg  [DIV_STEPS+1];
    logic [45:0]       num [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            num[i] = {sq_m_reg[SQRT_STEPS][i], 15'd0} >> 1;
            num[i] = num[i] + 46'(sq_root_reg[SQRT_STEPS] >> 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            dv_valid_reg[0] <= sq_valid_reg[SQRT_STEPS];
            dv_len_reg[0]   <= sq_root_reg[SQRT_STEPS];
            for (int i = 0; i < 3; i++)
            begin
                dv_rem_reg[0][i] <= {1'b0, num[i][45:15]};
                dv_low_reg[0][i] <= num[i][14:0];
                dv_q_reg[0][i]   <= '0;
            end
            dv_neg_reg[0]   <= sq_neg_reg[SQRT_STEPS];
            dv_zero_reg[0]  <= sq_zero_reg[SQRT_STEPS];
            dv_meta_reg[0]  <= sq_meta_reg[SQRT_STEPS];
        end
    end

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        logic [32:0] trial [3];
        logic [2:0]  ge;

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                trial[i] = {dv_rem_reg[k][i], dv_low_reg[k][i][14]};
                ge[i]    = trial[i] >= {1'b0, dv_len_reg[k]};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                dv_valid_reg[k+1] <= dv_valid_reg[k];
                dv_len_reg[k+1]   <= dv_len_reg[k];
                for (int i = 0; i < 3; i++)
                begin
                    dv_rem_reg[k+1][i] <= ge[i] ? 32'(trial[i] - {1'b0, dv_len_reg[k]})
                                                : trial[i][31:0];
                    dv_low_reg[k+1][i] <= {dv_low_reg[k][i][13:0], 1'b0};
                    dv_q_reg[k+1][i]   <= {dv_q_reg[k][i][13:0], ge[i]};
                end
                dv_neg_reg[k+1]   <= dv_neg_reg[k];
                dv_zero_reg[k+1]  <= dv_zero_reg[k];
                dv_meta_reg[k+1]  <= dv_meta_reg[k];
            end
        end
    end

    // restore signs
    logic              o_valid_reg;
    crg_q14_t [2:0]    o_q_reg;
    logic              o_zero_reg;
    crg_meta_t         o_meta_reg;
    crg_q14_t [2:0]    o_q_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            o_q_next[i] = dv_neg_reg[DIV_STEPS][i] ? -crg_q14_t'({1'b0, dv_q_reg[DIV_STEPS][i]})
                                                   : crg_q14_t'({1'b0, dv_q_reg[DIV_STEPS][i]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            o_valid_reg <= dv_valid_reg[DIV_STEPS];
            o_q_reg     <= o_q_next;
            o_zero_reg  <= dv_zero_reg[DIV_STEPS];
            o_meta_reg  <= dv_meta_reg[DIV_STEPS];
        end
    end

    assign out_valid = o_valid_reg;
    assign out_q     = o_q_reg;
    assign out_zero  = o_zero_reg;
    assign out_meta  = o_meta_reg;

endmodule

// ----- src/camera_ray_generator.sv -----
// Pinhole camera primary-ray generator, top level.
//
// Takes one pixel per clock when not held off or stalled and returns one ray
// per pixel, in order: the front forms the unnormalized direction, then the
// normalizer takes the square root (one bit per stage) and the divide. After
// reset and after any write to an orientation register the camera basis is
// rebuilt by sending the forward and right vectors through the same
// normalizer; pixels are held off while this runs. A stall on the ray side
// holds the whole pipeline.
module camera_ray_generator (
    input logic  clk,
    input logic  rst_n,
    crg_cfg_if.sink   cfg,
    crg_pix_if.sink   pix,
    crg_ray_if.source ray
);
    import crg_pkg::*;

    typedef enum logic [2:0] {
        ST_FWD_ISSUE,
        ST_FWD_WAIT,
        ST_RIGHT_ISSUE,
        ST_RIGHT_WAIT,
        ST_UP,
        ST_READY
    } state_t;

    function automatic crg_q14_t round_q14(input logic signed [33:0] p);
        logic [33:0] m;
        logic [33:0] r;
        m = p[33] ? 34'(-p) : p;
        r = (m + 34'd8192) >> 14;
        return p[33] ? -crg_q14_t'(r[15:0]) : crg_q14_t'(r[15:0]);
    endfunction

    logic signed [31:0] pos_x_reg, pos_y_reg, pos_z_reg;
    crg_q14_t           dir_x_reg, dir_y_reg, dir_z_reg;
    logic [31:0]        scale_reg;

    state_t             state_reg;
    logic               inflight_reg;
    logic               basis_bad_reg;
    crg_q14_t [2:0]     f_reg, r_reg, u_reg;

    logic               en;
    logic               in_fire;
    logic               front_empty;
    logic               issue;
    logic               ret;

    logic               nrm_valid;
    crg_wide_t [2:0]    nrm_v;
    crg_meta_t          nrm_meta;
    logic               nrm_out_valid;
    crg_q14_t [2:0]     nrm_q;
    logic               nrm_zero;
    crg_meta_t          nrm_out_meta;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            pos_z_reg <= '0;
            dir_x_reg <= '0;
            dir_y_reg <= '0;
            dir_z_reg <= DIR_Z_RESET;
            scale_reg <= SCALE_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_POS_X: pos_x_reg <= cfg.data;
                REG_POS_Y: pos_y_reg <= cfg.data;
                REG_POS_Z: pos_z_reg <= cfg.data;
                REG_DIR_X: dir_x_reg <= cfg.data[15:0];
                REG_DIR_Y: dir_y_reg <= cfg.data[15:0];
                REG_DIR_Z: dir_z_reg <= cfg.data[15:0];
                REG_SCALE: scale_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // pipeline front
    logic               p1_valid_reg, p2_valid_reg, p3_valid_reg;
    logic               p1_bad_reg, p2_bad_reg, p3_bad_reg;
    logic signed [46:0] p1_hu_reg, p1_hv_reg;
    logic signed [62:0] p2_pr_reg [3];
    logic signed [62:0] p2_pu_reg [3];
    crg_wide_t [2:0]    p3_c_reg;
    logic signed [13:0] dx_next, dy_next;
    logic               oob_next;

    assign en          = !ray.valid || ray.ready;
    assign in_fire     = pix.valid && pix.ready;
    assign pix.ready   = en && state_reg == ST_READY;
    assign front_empty = !p1_valid_reg && !p2_valid_reg && !p3_valid_reg;

    always_comb
    begin
        dx_next  = $signed({1'b0, pix.pixel_x, 1'b0}) - $signed(14'(FRAME_WIDTH));
        dy_next  = $signed(14'(FRAME_HEIGHT)) - $signed({1'b0, pix.pixel_y, 1'b0});
        oob_next = ({1'b0, pix.pixel_x} >= 13'(FRAME_WIDTH))
                || ({1'b0, pix.pixel_y} >= 13'(FRAME_HEIGHT));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_valid_reg <= in_fire;
            p1_bad_reg   <= oob_next || basis_bad_reg;
            p1_hu_reg    <= dx_next * $signed({1'b0, scale_reg});
            p1_hv_reg    <= dy_next * $signed({1'b0, scale_reg});
            p2_valid_reg <= p1_valid_reg;
            p2_bad_reg   <= p1_bad_reg;
            for (int i = 0; i < 3; i++)
            begin
                p2_pr_reg[i] <= p1_hu_reg * r_reg[i];
                p2_pu_reg[i] <= p1_hv_reg * u_reg[i];
            end
            p3_valid_reg <= p2_valid_reg;
            p3_bad_reg   <= p2_bad_reg;
            for (int i = 0; i < 3; i++)
            begin
                p3_c_reg[i] <= 64'(p2_pr_reg[i]) + 64'(p2_pu_reg[i])
                             + (64'(f_reg[i]) <<< 25);
            end
        end
    end

    // basis sequencer shares the normalizer
    assign issue = (state_reg == ST_FWD_ISSUE || state_reg == ST_RIGHT_ISSUE)
                && en && front_empty && !inflight_reg;
    assign ret   = en && nrm_out_valid && nrm_out_meta.kind != KIND_PIXEL;

    always_comb
    begin
        nrm_valid = p3_valid_reg || issue;
        nrm_v     = p3_c_reg;
        nrm_meta  = '{kind: KIND_PIXEL, pre_bad: p3_bad_reg};
        if (issue)
        begin
            if (state_reg == ST_FWD_ISSUE)
            begin
                nrm_v    = {64'(dir_z_reg), 64'(dir_y_reg), 64'(dir_x_reg)};
                nrm_meta = '{kind: KIND_FWD, pre_bad: 1'b0};
            end
            else
            begin
                nrm_v    = {64'(f_reg[0]), 64'sd0, -(64'(f_reg[2]))};
                nrm_meta = '{kind: KIND_RIGHT, pre_bad: 1'b0};
            end
        end
    end

    crg_norm3 u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (nrm_valid),
        .in_v      (nrm_v),
        .in_meta   (nrm_meta),
        .out_valid (nrm_out_valid),
        .out_q     (nrm_q),
        .out_zero  (nrm_zero),
        .out_meta  (nrm_out_meta)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FWD_ISSUE;
            inflight_reg  <= 1'b0;
            basis_bad_reg <= 1'b0;
        end
        else
        begin
            if (issue)
            begin
                inflight_reg <= 1'b1;
            end
            else if (ret)
            begin
                inflight_reg <= 1'b0;
            end
            if (cfg.valid && (cfg.index == REG_DIR_X || cfg.index == REG_DIR_Y
                              || cfg.index == REG_DIR_Z))
            begin
                state_reg <= ST_FWD_ISSUE;
            end
            else
            begin
                case (state_reg)
                    ST_FWD_ISSUE:
                    begin
                        if (issue)
                        begin
                            state_reg <= ST_FWD_WAIT;
                        end
                    end
                    ST_FWD_WAIT:
                    begin
                        if (ret && nrm_out_meta.kind == KIND_FWD)
                        begin
                            f_reg <= nrm_q;
                            if (nrm_zero)
                            begin
                                basis_bad_reg <= 1'b1;
                                state_reg     <= ST_READY;
                            end
                            else
                            begin
                                state_reg <= ST_RIGHT_ISSUE;
                            end
                        end
                    end
                    ST_RIGHT_ISSUE:
                    begin
                        if (issue)
                        begin
                            state_reg <= ST_RIGHT_WAIT;
                        end
                    end
                    ST_RIGHT_WAIT:
                    begin
                        if (ret && nrm_out_meta.kind == KIND_RIGHT)
                        begin
                            r_reg <= nrm_q;
                            if (nrm_zero)
                            begin
                                basis_bad_reg <= 1'b1;
                                state_reg     <= ST_READY;
                            end
                            else
                            begin
                                state_reg <= ST_UP;
                            end
                        end
                    end
                    ST_UP:
                    begin
                        u_reg[0] <= round_q14(-(34'(r_reg[2] * f_reg[1])));
                        u_reg[1] <= round_q14(34'(r_reg[2] * f_reg[0])
                                            - 34'(r_reg[0] * f_reg[2]));
                        u_reg[2] <= round_q14(34'(r_reg[0] * f_reg[1]));
                        basis_bad_reg <= 1'b0;
                        state_reg     <= ST_READY;
                    end
                    ST_READY: ;
                    default: state_reg <= ST_FWD_ISSUE;
                endcase
            end
        end
    end

    // output register
    logic           out_valid_reg;
    crg_q14_t [2:0] out_dir_reg;
    logic           out_degen_reg;
    logic           degen_next;

    assign degen_next = nrm_out_meta.pre_bad || nrm_zero;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= nrm_out_valid && nrm_out_meta.kind == KIND_PIXEL;
            out_dir_reg   <= degen_next ? '0 : nrm_q;
            out_degen_reg <= degen_next;
        end
    end

    assign ray.valid      = out_valid_reg;
    assign ray.origin_x   = pos_x_reg;
    assign ray.origin_y   = pos_y_reg;
    assign ray.origin_z   = pos_z_reg;
    assign ray.ray_dir_x  = out_dir_reg[0];
    assign ray.ray_dir_y  = out_dir_reg[1];
    assign ray.ray_dir_z  = out_dir_reg[2];
    assign ray.degenerate = out_degen_reg;

    a_issue_clear: assert property (@(posedge clk) disable iff (!rst_n)
        issue |-> !p3_valid_reg && !inflight_reg)
        else $error("basis vector issued into a busy normalizer");

    a_ret_tracked: assert property (@(posedge clk) disable iff (!rst_n)
        ret |-> inflight_reg)
        else $error("basis result returned with none outstanding");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(nrm_out_valid))
        else $error("transaction presented without a normalizer result");

endmodule

// ----- bench/camera_ray_generator_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the pinhole camera ray generator.
module camera_ray_generator_tb;
    import crg_pkg::*;

    localparam int WATCHDOG_LIMIT    = 20000;
    localparam int RANDOM_ITEMS      = 1400;
    localparam int NUM_DIRECTED      = 14;
    localparam int LONG_STALL_CYCLES = 400;

    localparam logic [2:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic [31:0] ox;
        logic [31:0] oy;
        logic [31:0] oz;
        logic [15:0] dx;
        logic [15:0] dy;
        logic [15:0] dz;
        logic        degen;
    } ray_t;

    typedef struct packed {
        logic [11:0] px;
        logic [11:0] py;
        logic        known;
        logic [15:0] dx;
        logic [15:0] dy;
        logic [15:0] dz;
        logic        degen;
    } pixel_row_t;

    logic clk;
    logic rst_n;
    int   error_count;
    int   idle_cycles;
    int   stall_cycles;
    bit   stall_long;

    logic [31:0] pos_x, pos_y, pos_z, scale;
    logic [15:0] dir_x, dir_y, dir_z;

    ray_t       expected_rays[$];
    pixel_row_t directed_rows[NUM_DIRECTED];

    crg_cfg_if cfg ();
    crg_pix_if pix ();
    crg_ray_if ray ();

    camera_ray_generator u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg.sink),
        .pix   (pix.sink),
        .ray   (ray.source)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic bit unit_vector(input longint v[3], output int q[3]);
        logic [63:0] m[3];
        logic [63:0] mx;
        logic [63:0] len;
        logic [63:0] r;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = (v[i] < 0) ? -v[i] : v[i];
            q[i] = 0;
        end
        mx = m[0];
        if (m[1] > mx) mx = m[1];
        if (m[2] > mx) mx = m[2];
        if (mx == 0)
            return 0;
        while (mx >= (64'd1 << 31))
        begin
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
            mx = mx >> 1;
        end
        while (mx < (64'd1 << 30))
        begin
            for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
            mx = mx << 1;
        end
        len = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
        for (int i = 0; i < 3; i++)
        begin
            r = ((m[i] << 14) + (len >> 1)) / len;
            q[i] = (v[i] < 0) ? -int'(r) : int'(r);
        end
        return 1;
    endfunction

    function automatic int round_to_q14(longint p);
        longint r;
        r = (((p < 0) ? -p : p) + 8192) >>> 14;
        return (p < 0) ? -int'(r) : int'(r);
    endfunction

    function automatic ray_t trace_pixel(logic [11:0] px, logic [11:0] py);
        ray_t   res;
        longint o[3], c[3];
        longint hu, hv;
        int     f[3], r[3], u[3], d[3];
        bit     ok;
        d = '{0, 0, 0};
        ok = (px < FRAME_WIDTH) && (py < FRAME_HEIGHT);
        o[0] = longint'($signed(dir_x));
        o[1] = longint'($signed(dir_y));
        o[2] = longint'($signed(dir_z));
        if (ok)
            ok = unit_vector(o, f);
        if (ok)
        begin
            c[0] = -f[2];
            c[1] = 0;
            c[2] = f[0];
            ok = unit_vector(c, r);
        end
        if (ok)
        begin
            u[0] = round_to_q14(-longint'(r[2]) * f[1]);
            u[1] = round_to_q14(longint'(r[2]) * f[0] - longint'(r[0]) * f[2]);
            u[2] = round_to_q14(longint'(r[0]) * f[1]);
            hu = (2 * longint'(px) - FRAME_WIDTH) * longint'({32'd0, scale});
            hv = (FRAME_HEIGHT - 2 * longint'(py)) * longint'({32'd0, scale});
            for (int i = 0; i < 3; i++)
                c[i] = longint'(r[i]) * hu + longint'(u[i]) * hv
                     + longint'(f[i]) * (longint'(1) << 25);
            ok = unit_vector(c, d);
        end
        if (!ok)
            d = '{0, 0, 0};
        res.ox = pos_x;
        res.oy = pos_y;
        res.oz = pos_z;
        res.dx = d[0][15:0];
        res.dy = d[1][15:0];
        res.dz = d[2][15:0];
        res.degen = !ok;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_POS_X: pos_x = value;
            REG_POS_Y: pos_y = value;
            REG_POS_Z: pos_z = value;
            REG_DIR_X: dir_x = value[15:0];
            REG_DIR_Y: dir_y = value[15:0];
            REG_DIR_Z: dir_z = value[15:0];
            REG_SCALE: scale = value;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (expected_rays.size() != 0)
            @(posedge clk);
        repeat (70) @(posedge clk);
    endtask

    task automatic send_pixel(logic [11:0] px, logic [11:0] py, bit use_gap);
        int unsigned gap;
        gap = use_gap ? pick_gap() : 0;
        if (gap != 0)
        begin
            pix.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix.valid   <= 1'b1;
        pix.pixel_x <= px;
        pix.pixel_y <= py;
        @(posedge clk);
        while (!pix.ready)
            @(posedge clk);
        expected_rays.push_back(trace_pixel(px, py));
    endtask

    task automatic end_burst();
        pix.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_camera();
        int unsigned mode;
        mode = $urandom_range(0, 9);
        write_reg(REG_POS_X, $urandom());
        write_reg(REG_POS_Y, $urandom());
        write_reg(REG_POS_Z, $urandom());
        if (mode == 0)
        begin
            write_reg(REG_DIR_X, 32'd0);
            write_reg(REG_DIR_Y, $urandom_range(0, 1) ? 32'h8000 : 32'h0);
            write_reg(REG_DIR_Z, 32'd0);
        end
        else
        begin
            write_reg(REG_DIR_X, $urandom());
            write_reg(REG_DIR_Y, $urandom());
            write_reg(REG_DIR_Z, $urandom());
        end
        case ($urandom_range(0, 5))
            0: write_reg(REG_SCALE, $urandom());
            1: write_reg(REG_SCALE, 32'hFFFF_FFFF);
            2: write_reg(REG_SCALE, 32'd0);
            default: write_reg(REG_SCALE, $urandom_range(1000, 200000));
        endcase
    endtask

    initial
    begin
        directed_rows[0]  = '{12'd512,  12'd384,  1'b1, 16'd0, 16'd0, 16'd16384, 1'b0};
        directed_rows[1]  = '{12'd0,    12'd0,    1'b0, 16'd0, 16'd0, 16'd0, 1'b0};
        directed_rows[2]  = '{12'd1023, 12'd767,  1'b0, 16'd0, 16'd0, 16'd0, 1'b0};
        directed_rows[3]  = '{12'd1023, 12'd0,    1'b0, 16'd0, 16'd0, 16'd0, 1'b0};
        directed_rows[4]  = '{12'd0,    12'd767,  1'b0, 16'd0, 16'd0, 16'd0, 1'b0};
        directed_rows[5]  = '{12'd1024, 12'd10,   1'b1, 16'd0, 16'd0, 16'd0, 1'b1};
        directed_rows[6]  = '{12'd10,   12'd768,  1'b1, 16'd0, 16'd0, 16'd0, 1'b1};
        directed_rows[7]  = '{12'd4095, 12'd4095, 1'b1, 16'd0, 16'd0, 16'd0, 1'b1};
        directed_rows[8]  = '{12'd4095, 12'd0,    1'b1, 16'd0, 16'd0, 16'd0, 1'b1};
        directed_rows[9]  = '{12'd0,    12'd4095, 1'b1, 16'd0, 16'd0, 16'd0, 1'b1};
        directed_rows[10] = '{12'hAAA & 12'd1023, 12'h555, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0};
        directed_rows[11] = '{12'd300,  12'd200,  1'b0, 16'd0, 16'd0, 16'd0, 1'b0};
        directed_rows[12] = '{12'd512,  12'd0,    1'b0, 16'd0, 16'd0, 16'd0, 1'b0};
        directed_rows[13] = '{12'd0,    12'd384,  1'b0, 16'd0, 16'd0, 16'd0, 1'b0};
    end

    // hold off for a fixed number of cycles once a long stall is requested
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            ray.ready    <= 1'b0;
            stall_cycles <= 0;
        end
        else if (stall_long && stall_cycles < LONG_STALL_CYCLES)
        begin
            ray.ready    <= 1'b0;
            stall_cycles <= stall_cycles + 1;
        end
        else
            ray.ready <= ($urandom_range(0, 9) < 7) || ($urandom_range(0, 3) == 0);
    end

    always @(posedge clk)
    begin
        ray_t want;
        if (rst_n && ray.valid && ray.ready)
        begin
            if (expected_rays.size() == 0)
                report_mismatch("unexpected ray", 32'd0, 32'd0);
            else
            begin
                want = expected_rays.pop_front();
                if (ray.origin_x !== want.ox) report_mismatch("origin_x", ray.origin_x, want.ox);
                if (ray.origin_y !== want.oy) report_mismatch("origin_y", ray.origin_y, want.oy);
                if (ray.origin_z !== want.oz) report_mismatch("origin_z", ray.origin_z, want.oz);
                if (ray.ray_dir_x !== want.dx)
                    report_mismatch("ray_dir_x", 32'(ray.ray_dir_x), 32'(want.dx));
                if (ray.ray_dir_y !== want.dy)
                    report_mismatch("ray_dir_y", 32'(ray.ray_dir_y), 32'(want.dy));
                if (ray.ray_dir_z !== want.dz)
                    report_mismatch("ray_dir_z", 32'(ray.ray_dir_z), 32'(want.dz));
                if (ray.degenerate !== want.degen)
                    report_mismatch("degenerate", 32'(ray.degenerate), 32'(want.degen));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (pix.valid && pix.ready) || (ray.valid && ray.ready)
            || (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("camera_ray_generator_tb: errors");
            $finish;
        end
    end

    initial
    begin
        ray_t want;
        int   n;
        rst_n = 1'b0;
        error_count = 0;
        idle_cycles = 0;
        stall_long = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = REG_POS_X;
        cfg.data = '0;
        pix.valid = 1'b0;
        pix.pixel_x = '0;
        pix.pixel_y = '0;
        ray.ready = 1'b0;
        pos_x = 0;
        pos_y = 0;
        pos_z = 0;
        dir_x = 0;
        dir_y = 0;
        dir_z = DIR_Z_RESET;
        scale = SCALE_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int pass = 0; pass < 4; pass++)
        begin
            case (pass)
                1:
                begin
                    write_reg(REG_POS_X, 32'h7FFF_FFFF);
                    write_reg(REG_POS_Y, 32'h8000_0000);
                    write_reg(REG_POS_Z, 32'hFFFF_FFFF);
                    write_reg(REG_DIR_X, 32'h7FFF);
                    write_reg(REG_DIR_Y, 32'h8000);
                    write_reg(REG_DIR_Z, 32'h7FFF);
                    write_reg(REG_SCALE, 32'hFFFF_FFFF);
                    write_reg(REG_UNUSED, 32'h1234_5678);
                end
                2:
                begin
                    write_reg(REG_DIR_X, 32'h0);
                    write_reg(REG_DIR_Y, 32'h0);
                    write_reg(REG_DIR_Z, 32'h0);
                    write_reg(REG_SCALE, 32'h0);
                end
                3:
                begin
                    write_reg(REG_DIR_Y, 32'h4000);
                    write_reg(REG_SCALE, 32'd29360);
                end
                default: ;
            endcase
            for (int i = 0; i < NUM_DIRECTED; i++)
            begin
                send_pixel(directed_rows[i].px, directed_rows[i].py, 1'b1);
                want = expected_rays[$];
                if (pass == 0 && directed_rows[i].known &&
                    (want.dx !== directed_rows[i].dx || want.dy !== directed_rows[i].dy ||
                     want.dz !== directed_rows[i].dz || want.degen !== directed_rows[i].degen))
                    report_mismatch("directed row", i, 0);
            end
            end_burst();
            wait_drained();
        end

        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            random_camera();
            for (int k = 0; k < 150 && n < RANDOM_ITEMS; k++)
            begin
                if ($urandom_range(0, 19) == 0)
                    send_pixel($urandom(), $urandom(), 1'b1);
                else
                    send_pixel($urandom_range(0, FRAME_WIDTH - 1),
                               $urandom_range(0, FRAME_HEIGHT - 1), k > 60);
                n++;
                if (k == 20 && n < 200)
                    stall_long = 1'b1;
            end
            end_burst();
            wait_drained();
        end

        if (error_count == 0)
            $display("camera_ray_generator_tb: clean");
        else
            $display("camera_ray_generator_tb: errors");
        $finish;
    end
endmodule
